>>> rtl/gmg_pkg.sv
// ----------------------------------------------------------------------------
// gmg_pkg
// Shared types, codes and helpers of the grid maze generator.
// ----------------------------------------------------------------------------
package gmg_pkg;

    localparam int GMG_MAX_SIDE = 64;
    localparam int GMG_MAX_TRIES = 64;
    localparam int RND_W = 16;
    localparam int TRY_W = $clog2(GMG_MAX_TRIES);

    localparam logic [1:0] MODE_GEN = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_SEED = 2'd2;

    localparam logic [1:0] REG_GRID_SIDE = 2'd0;
    localparam logic [1:0] REG_MIX_VALUE = 2'd1;

    localparam logic [1:0] DIR_LEFT = 2'd0;
    localparam logic [1:0] DIR_TOP = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_BOTTOM = 2'd3;

    localparam logic [6:0] SIDE_RESET = 7'd10;
    localparam logic [4:0] CELL_CLOSED = 5'h0F;
    localparam logic [4:0] CELL_VISITED = 5'h10;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SEED,
        OP_CLR_INIT,
        OP_CLR,
        OP_DRAW_MOD,
        OP_SET_X,
        OP_SET_Y,
        OP_HERE,
        OP_RD_HERE,
        OP_MARK,
        OP_RD_NB,
        OP_BACK,
        OP_POP,
        OP_TRY_INIT,
        OP_DRAW4,
        OP_PUSH,
        OP_CARVE,
        OP_RADDR,
        OP_RD_CELL,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] nb_dir;
        logic       take;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       mod_busy;
        logic [3:0] avail;
        logic       depth_zero;
        logic       draw_done;
        logic       out_busy;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED,
        ST_CLR_INIT,
        ST_CLR,
        ST_DX,
        ST_DXW,
        ST_DY,
        ST_DYW,
        ST_HERE,
        ST_RDH,
        ST_MARK,
        ST_N0,
        ST_N1,
        ST_N2,
        ST_N3,
        ST_NW,
        ST_DECIDE,
        ST_TRY,
        ST_POP,
        ST_PUSH,
        ST_CARVE,
        ST_RA,
        ST_RM,
        ST_FIN
    } state_t;

    function automatic logic [RND_W-1:0] gmg_xorshift(input logic [RND_W-1:0] s);
        logic [RND_W-1:0] t;
        t = s ^ (s << 7);
        t = t ^ (t >> 1);
        t = t ^ (t << 9);
        return t;
    endfunction

endpackage

>>> rtl/gmg_mod_unit.sv
// ----------------------------------------------------------------------------
// gmg_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gmg_mod_unit
    import gmg_pkg::*;
#(
    parameter int SW = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [SW-1:0]    divisor,
    output logic             busy,
    output logic [SW-1:0]    remainder
);

    localparam int CW = $clog2(RND_W + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [RND_W-1:0] dvd_reg, dvd_next;
    logic [SW:0]      rem_reg, rem_next;
    logic [SW-1:0]    dsr_reg, dsr_next;
    logic [SW:0]      shifted;

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        shifted = {rem_reg[SW-1:0], dvd_reg[RND_W-1]};
        if (start)
        begin
            cnt_next = CW'(RND_W);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = dvd_reg << 1;
            if (shifted >= {1'b0, dsr_reg})
                rem_next = shifted - {1'b0, dsr_reg};
            else
                rem_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != '0);
    assign remainder = rem_reg[SW-1:0];

endmodule

>>> rtl/gmg_datapath.sv
// ----------------------------------------------------------------------------
// gmg_datapath
// Cell store, walk stack, random source and result registers of the maze.
// ----------------------------------------------------------------------------
module gmg_datapath
    import gmg_pkg::*;
#(
    parameter int MAX_SIDE = GMG_MAX_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  mode,
    input  logic [5:0]  col,
    input  logic [5:0]  row,
    input  logic [15:0] seed_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  walls,
    output logic [5:0]  start_col,
    output logic [5:0]  start_row,
    output logic [5:0]  target_col,
    output logic [5:0]  target_row,
    output logic [12:0] deepest_depth
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW = $clog2(CELLS);
    localparam int XW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int DW = $clog2(CELLS + 1);

    logic [4:0]      cell_mem [CELLS];
    logic [2*XW-1:0] stack_mem [CELLS];

    logic [6:0]       side_cfg_reg;
    logic [15:0]      mix_reg;
    logic [SW-1:0]    side;
    logic [1:0]       mode_reg;
    logic [5:0]       col_reg, row_reg;
    logic [15:0]      seedin_reg;
    logic [RND_W-1:0] seed_reg, seed_next;
    logic [XW-1:0]    x_reg, x_next, y_reg, y_next;
    logic [AW-1:0]    here_reg, here_next;
    logic [AW:0]      sq_reg;
    logic [AW-1:0]    cnt_reg;
    logic [DW-1:0]    depth_reg, depth_next, best_reg, best_next;
    logic [XW-1:0]    sx_reg, sy_reg, tx_reg, ty_reg;
    logic [XW-1:0]    sx_next, sy_next, tx_next, ty_next;
    logic [4:0]       cur_reg;
    logic [3:0]       avail_reg, avail_next;
    logic [1:0]       dir_reg, dir_next;
    logic [TRY_W-1:0] tries_reg, tries_next;
    logic             nb_pend_reg, nb_ok_reg;
    logic [1:0]       nb_dir_reg;
    logic [AW-1:0]    raddr_reg;
    logic             inside_reg;
    logic [4:0]       rd_data_reg;
    logic [2*XW-1:0]  stk_rd_reg;
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       o_walls_reg;
    logic [5:0]       o_sc_reg, o_sr_reg, o_tc_reg, o_tr_reg;
    logic [12:0]      o_dd_reg;

    logic [RND_W-1:0] t;
    logic [1:0]       draw_idx;
    logic             hit;
    logic [1:0]       low_dir;
    logic             mod_busy;
    logic [SW-1:0]    mod_rem;
    logic [AW-1:0]    side_w, x_w, y_w;
    logic [AW-1:0]    nb_addr, mv_addr;
    logic             nb_ok;
    logic [XW-1:0]    side_m1;
    logic [3:0]       wall_bit, opp_bit;
    logic             we, re, stk_we, stk_re;
    logic [AW-1:0]    wa, ra;
    logic [4:0]       wd;

    always_comb
    begin
        if (int'(side_cfg_reg) < 2)
            side = SW'(2);
        else if (int'(side_cfg_reg) > MAX_SIDE)
            side = SW'(MAX_SIDE);
        else
            side = SW'(side_cfg_reg);
    end

    assign side_w = AW'(side);
    assign x_w = AW'(x_reg);
    assign y_w = AW'(y_reg);
    assign side_m1 = XW'(side - SW'(1));
    assign t = gmg_xorshift(seed_reg);
    assign draw_idx = t[1:0];
    assign hit = avail_reg[draw_idx];
    assign wall_bit = 4'b0001 << dir_reg;
    assign opp_bit = 4'b0001 << (dir_reg ^ 2'b10);

    always_comb
    begin
        priority if (avail_reg[0])
            low_dir = DIR_LEFT;
        else if (avail_reg[1])
            low_dir = DIR_TOP;
        else if (avail_reg[2])
            low_dir = DIR_RIGHT;
        else
            low_dir = DIR_BOTTOM;
    end

    always_comb
    begin
        unique case (cmd.nb_dir)
            DIR_LEFT:
            begin
                nb_addr = here_reg - AW'(1);
                nb_ok = (x_reg != '0);
            end
            DIR_TOP:
            begin
                nb_addr = here_reg - side_w;
                nb_ok = (y_reg != '0);
            end
            DIR_RIGHT:
            begin
                nb_addr = here_reg + AW'(1);
                nb_ok = (x_reg != side_m1);
            end
            default:
            begin
                nb_addr = here_reg + side_w;
                nb_ok = (y_reg != side_m1);
            end
        endcase
    end

    always_comb
    begin
        unique case (dir_reg)
            DIR_LEFT:   mv_addr = here_reg - AW'(1);
            DIR_TOP:    mv_addr = here_reg - side_w;
            DIR_RIGHT:  mv_addr = here_reg + AW'(1);
            default:    mv_addr = here_reg + side_w;
        endcase
    end

    gmg_mod_unit #(
        .SW(SW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.op == OP_DRAW_MOD),
        .dividend  (t),
        .divisor   (side),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_comb
    begin
        we = 1'b0;
        wa = here_reg;
        wd = CELL_CLOSED;
        re = 1'b0;
        ra = here_reg;
        stk_we = 1'b0;
        stk_re = 1'b0;
        seed_next = seed_reg;
        x_next = x_reg;
        y_next = y_reg;
        here_next = here_reg;
        depth_next = depth_reg;
        best_next = best_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        avail_next = avail_reg;
        dir_next = dir_reg;
        tries_next = tries_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (nb_pend_reg)
            avail_next[nb_dir_reg] = nb_ok_reg && !rd_data_reg[4];
        unique case (cmd.op)
            OP_SEED:
                seed_next = seedin_reg;
            OP_CLR_INIT:
                best_next = '0;
            OP_CLR:
            begin
                we = 1'b1;
                wa = cnt_reg;
            end
            OP_DRAW_MOD:
                seed_next = mix_reg + t;
            OP_SET_X:
                x_next = XW'(mod_rem);
            OP_SET_Y:
            begin
                y_next = XW'(mod_rem);
                sx_next = x_reg;
                sy_next = XW'(mod_rem);
                depth_next = '0;
            end
            OP_HERE:
                here_next = y_w * side_w + x_w;
            OP_RD_HERE:
                re = 1'b1;
            OP_MARK:
            begin
                we = 1'b1;
                wd = rd_data_reg | CELL_VISITED;
                avail_next = '0;
            end
            OP_RD_NB:
            begin
                re = 1'b1;
                ra = nb_addr;
            end
            OP_BACK:
            begin
                if (best_reg < depth_reg)
                begin
                    best_next = depth_reg;
                    tx_next = x_reg;
                    ty_next = y_reg;
                end
                depth_next = depth_reg - 1'b1;
                stk_re = 1'b1;
            end
            OP_POP:
            begin
                x_next = stk_rd_reg[XW-1:0];
                y_next = stk_rd_reg[2*XW-1:XW];
            end
            OP_TRY_INIT:
                tries_next = '0;
            OP_DRAW4:
            begin
                seed_next = mix_reg + t;
                tries_next = tries_reg + 1'b1;
                if (hit)
                    dir_next = draw_idx;
                else
                    dir_next = low_dir;
            end
            OP_PUSH:
            begin
                we = 1'b1;
                wd = cur_reg & ~{1'b0, wall_bit};
                if (int'(depth_reg) < CELLS)
                begin
                    stk_we = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            OP_CARVE:
            begin
                we = 1'b1;
                wa = mv_addr;
                wd = CELL_CLOSED & ~{1'b0, opp_bit};
                here_next = mv_addr;
                unique case (dir_reg)
                    DIR_LEFT:   x_next = x_reg - 1'b1;
                    DIR_TOP:    y_next = y_reg - 1'b1;
                    DIR_RIGHT:  x_next = x_reg + 1'b1;
                    default:    y_next = y_reg + 1'b1;
                endcase
            end
            OP_RD_CELL:
            begin
                re = 1'b1;
                ra = raddr_reg;
            end
            OP_RESULT:
                out_valid_next = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= SIDE_RESET;
            mix_reg <= '0;
            seed_reg <= RND_W'(1);
            depth_reg <= '0;
            best_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            tx_reg <= '0;
            ty_reg <= '0;
            nb_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_GRID_SIDE)
                side_cfg_reg <= cfg_data[6:0];
            if (cfg_we && cfg_index == REG_MIX_VALUE)
                mix_reg <= cfg_data;
            seed_reg <= seed_next;
            depth_reg <= depth_next;
            best_reg <= best_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
            nb_pend_reg <= (cmd.op == OP_RD_NB);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg <= mode;
            col_reg <= col;
            row_reg <= row;
            seedin_reg <= seed_value;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        here_reg <= here_next;
        avail_reg <= avail_next;
        dir_reg <= dir_next;
        tries_reg <= tries_next;
        nb_dir_reg <= cmd.nb_dir;
        nb_ok_reg <= nb_ok;
        if (cmd.op == OP_CLR_INIT)
        begin
            sq_reg <= (AW + 1)'(side_w) * (AW + 1)'(side_w);
            cnt_reg <= '0;
        end
        else if (cmd.op == OP_CLR)
            cnt_reg <= cnt_reg + 1'b1;
        if (cmd.op == OP_MARK)
            cur_reg <= rd_data_reg | CELL_VISITED;
        if (cmd.op == OP_RADDR)
        begin
            raddr_reg <= AW'(row_reg) * side_w + AW'(col_reg);
            inside_reg <= (int'(col_reg) < int'(side)) && (int'(row_reg) < int'(side));
        end
        if (cmd.op == OP_RESULT)
        begin
            if (mode_reg == MODE_READ)
                o_walls_reg <= inside_reg ? rd_data_reg[3:0] : 4'hF;
            else
                o_walls_reg <= 4'h0;
            o_sc_reg <= 6'(sx_reg);
            o_sr_reg <= 6'(sy_reg);
            o_tc_reg <= 6'(tx_reg);
            o_tr_reg <= 6'(ty_reg);
            o_dd_reg <= 13'(best_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            cell_mem[wa] <= wd;
        if (re)
            rd_data_reg <= cell_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[depth_reg[AW-1:0]] <= {y_reg, x_reg};
        if (stk_re)
            stk_rd_reg <= stack_mem[AW'(depth_reg - 1'b1)];
    end

    assign status.clr_last = ({1'b0, cnt_reg} == sq_reg - 1'b1);
    assign status.mod_busy = mod_busy;
    assign status.avail = avail_reg;
    assign status.depth_zero = (depth_reg == '0);
    assign status.draw_done = hit || (tries_reg == TRY_W'(GMG_MAX_TRIES - 1));
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign walls = o_walls_reg;
    assign start_col = o_sc_reg;
    assign start_row = o_sr_reg;
    assign target_col = o_tc_reg;
    assign target_row = o_tr_reg;
    assign deepest_depth = o_dd_reg;

endmodule

>>> rtl/gmg_ctrl.sv
// ----------------------------------------------------------------------------
// gmg_ctrl
// Maze sequencer: seed, clear, draw, walk, backtrack, cell read, answer.
// ----------------------------------------------------------------------------
module gmg_ctrl
    import gmg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        cmd.nb_dir = DIR_LEFT;
        cmd.take = 1'b0;
        in_ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (mode)
                        MODE_GEN:  state_next = ST_CLR_INIT;
                        MODE_READ: state_next = ST_RA;
                        MODE_SEED: state_next = ST_SEED;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_SEED:
            begin
                cmd.op = OP_SEED;
                state_next = ST_FIN;
            end
            ST_CLR_INIT:
            begin
                cmd.op = OP_CLR_INIT;
                state_next = ST_CLR;
            end
            ST_CLR:
            begin
                cmd.op = OP_CLR;
                if (status.clr_last)
                    state_next = ST_DX;
            end
            ST_DX:
            begin
                cmd.op = OP_DRAW_MOD;
                state_next = ST_DXW;
            end
            ST_DXW:
            begin
                if (!status.mod_busy)
                begin
                    cmd.op = OP_SET_X;
                    state_next = ST_DY;
                end
            end
            ST_DY:
            begin
                cmd.op = OP_DRAW_MOD;
                state_next = ST_DYW;
            end
            ST_DYW:
            begin
                if (!status.mod_busy)
                begin
                    cmd.op = OP_SET_Y;
                    state_next = ST_HERE;
                end
            end
            ST_HERE:
            begin
                cmd.op = OP_HERE;
                state_next = ST_RDH;
            end
            ST_RDH:
            begin
                cmd.op = OP_RD_HERE;
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                cmd.op = OP_MARK;
                state_next = ST_N0;
            end
            ST_N0:
            begin
                cmd.op = OP_RD_NB;
                cmd.nb_dir = DIR_LEFT;
                state_next = ST_N1;
            end
            ST_N1:
            begin
                cmd.op = OP_RD_NB;
                cmd.nb_dir = DIR_TOP;
                state_next = ST_N2;
            end
            ST_N2:
            begin
                cmd.op = OP_RD_NB;
                cmd.nb_dir = DIR_RIGHT;
                state_next = ST_N3;
            end
            ST_N3:
            begin
                cmd.op = OP_RD_NB;
                cmd.nb_dir = DIR_BOTTOM;
                state_next = ST_NW;
            end
            ST_NW:
                state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (status.avail != '0)
                begin
                    cmd.op = OP_TRY_INIT;
                    state_next = ST_TRY;
                end
                else if (status.depth_zero)
                    state_next = ST_FIN;
                else
                begin
                    cmd.op = OP_BACK;
                    state_next = ST_POP;
                end
            end
            ST_TRY:
            begin
                cmd.op = OP_DRAW4;
                if (status.draw_done)
                    state_next = ST_PUSH;
            end
            ST_POP:
            begin
                cmd.op = OP_POP;
                state_next = ST_HERE;
            end
            ST_PUSH:
            begin
                cmd.op = OP_PUSH;
                state_next = ST_CARVE;
            end
            ST_CARVE:
            begin
                cmd.op = OP_CARVE;
                state_next = ST_RDH;
            end
            ST_RA:
            begin
                cmd.op = OP_RADDR;
                state_next = ST_RM;
            end
            ST_RM:
            begin
                cmd.op = OP_RD_CELL;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.op = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/grid_maze_generator_unit.sv
// ----------------------------------------------------------------------------
// grid_maze_generator_unit
// Depth-first maze generator on a square grid with cell read-back.
// ----------------------------------------------------------------------------
//   channel | signals                          | direction
//   in      | in_valid/in_ready, mode..seed    | request in
//   out     | out_valid/out_ready, walls..     | result out
//   cfg     | cfg_valid/cfg_ready, index, data | register write in
//
// Seed load passes the seed and finish steps, mode 3 only the finish step and
// a cell read the address, read and finish steps; the result turns valid as
// the sequencer returns to idle. Generation clears side*side cells one per
// cycle, draws the start through the remainder unit twice, then visits and
// backtracks cell by cell, drawing random directions on each visit.
// Reset leaves the cell store and stack undefined; no clearing pass.
// A request is taken only when the sequencer is idle; a pending result holds
// the finish step until out_ready.
// ----------------------------------------------------------------------------
module grid_maze_generator_unit
    import gmg_pkg::*;
#(
    parameter int MAX_SIDE = GMG_MAX_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [5:0]  col,
    input  logic [5:0]  row,
    input  logic [15:0] seed_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  walls,
    output logic [5:0]  start_col,
    output logic [5:0]  start_row,
    output logic [5:0]  target_col,
    output logic [5:0]  target_row,
    output logic [12:0] deepest_depth,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    gmg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    gmg_datapath #(
        .MAX_SIDE(MAX_SIDE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .col           (col),
        .row           (row),
        .seed_value    (seed_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .walls         (walls),
        .start_col     (start_col),
        .start_row     (start_row),
        .target_col    (target_col),
        .target_row    (target_row),
        .deepest_depth (deepest_depth)
    );

endmodule
